// ===== hw/rtl/aarf_pkg.sv =====
// Package with the request codes, flag positions and shared types of the execute unit.
package aarf_pkg;

    // Register file geometry
    localparam int NumRegs   = 7;
    localparam int IdxW      = 3;
    localparam int DataW     = 8;
    localparam int NumFlags  = 4;

    // Flag bit positions inside the flag register
    localparam int FlagCarry  = 0;
    localparam int FlagZero   = 1;
    localparam int FlagSign   = 2;
    localparam int FlagParity = 3;

    // Register index that names memory and is rejected
    localparam logic [IdxW-1:0] IdxMemory = 3'd7;
    localparam logic [IdxW-1:0] IdxAcc    = 3'd0;

    // Stream payload widths
    localparam int InDataW  = 24;
    localparam int OutDataW = 16;

    // Request kinds
    typedef enum logic [2:0] {
        REQ_ALU    = 3'd0,
        REQ_ROTATE = 3'd1,
        REQ_INC    = 3'd2,
        REQ_DEC    = 3'd3,
        REQ_WRITE  = 3'd4,
        REQ_READ   = 3'd5
    } req_type_t;

    // ALU operations
    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_ADC = 3'd1,
        ALU_SUB = 3'd2,
        ALU_SBB = 3'd3,
        ALU_AND = 3'd4,
        ALU_XOR = 3'd5,
        ALU_OR  = 3'd6,
        ALU_CMP = 3'd7
    } alu_op_t;

    // Rotate operations, taken from the low two bits of op_sel
    typedef enum logic [1:0] {
        ROT_RLC = 2'd0,
        ROT_RRC = 2'd1,
        ROT_RAL = 2'd2,
        ROT_RAR = 2'd3
    } rot_op_t;

    // One decoded request as it enters the execute logic
    typedef struct packed {
        logic [2:0]       req_type;
        logic [2:0]       op_sel;
        logic [IdxW-1:0]  reg_index;
        logic [DataW-1:0] operand;
    } req_t;

    // What the execute logic hands back for one request
    typedef struct packed {
        logic [DataW-1:0]    value;
        logic [NumFlags-1:0] flags;
        logic                bad;
        logic                we;
        logic [IdxW-1:0]     widx;
        logic [DataW-1:0]    wdata;
    } exec_t;

endpackage

// ===== hw/rtl/aarf_exec.sv =====
// Combinational execute logic: ALU, rotates, increment, decrement, register write and read.
module aarf_exec (
    input  aarf_pkg::req_t                     req,
    input  logic [aarf_pkg::DataW-1:0]         acc,
    input  logic [aarf_pkg::DataW-1:0]         sel_val,
    input  logic [aarf_pkg::NumFlags-1:0]      flags,
    output aarf_pkg::exec_t                    res
);

    logic                          cin;
    logic [aarf_pkg::DataW:0]      add_sum;
    logic [aarf_pkg::DataW:0]      sub_diff;
    logic                          use_cin;
    logic [aarf_pkg::DataW-1:0]    zsp_val;
    logic                          zsp_en;
    logic                          idx_bad;

    assign cin     = flags[aarf_pkg::FlagCarry];
    assign use_cin = (aarf_pkg::alu_op_t'(req.op_sel) == aarf_pkg::ALU_ADC) ||
                     (aarf_pkg::alu_op_t'(req.op_sel) == aarf_pkg::ALU_SBB);

    // Shared 9-bit adder and subtractor; bit eight is carry or borrow.
    assign add_sum  = {1'b0, acc} + {1'b0, req.operand} + {{aarf_pkg::DataW{1'b0}}, use_cin & cin};
    assign sub_diff = {1'b0, acc} - {1'b0, req.operand} - {{aarf_pkg::DataW{1'b0}}, use_cin & cin};

    // Index 7 is rejected for the register requests only.
    assign idx_bad = (req.reg_index == aarf_pkg::IdxMemory) &&
                     ((aarf_pkg::req_type_t'(req.req_type) == aarf_pkg::REQ_INC)   ||
                      (aarf_pkg::req_type_t'(req.req_type) == aarf_pkg::REQ_DEC)   ||
                      (aarf_pkg::req_type_t'(req.req_type) == aarf_pkg::REQ_WRITE) ||
                      (aarf_pkg::req_type_t'(req.req_type) == aarf_pkg::REQ_READ));

    // Operation select; zero, sign and parity are applied afterwards.
    always_comb
    begin
        res        = '0;
        res.flags  = flags;
        res.bad    = idx_bad;
        res.widx   = req.reg_index;
        zsp_en     = 1'b0;
        zsp_val    = '0;
        if (!idx_bad)
        begin
            unique case (aarf_pkg::req_type_t'(req.req_type))
                aarf_pkg::REQ_ALU:
                begin
                    res.widx = aarf_pkg::IdxAcc;
                    zsp_en   = 1'b1;
                    res.we   = 1'b1;
                    unique case (aarf_pkg::alu_op_t'(req.op_sel))
                        aarf_pkg::ALU_ADD, aarf_pkg::ALU_ADC:
                        begin
                            zsp_val                       = add_sum[aarf_pkg::DataW-1:0];
                            res.flags[aarf_pkg::FlagCarry] = add_sum[aarf_pkg::DataW];
                        end
                        aarf_pkg::ALU_SUB, aarf_pkg::ALU_SBB:
                        begin
                            zsp_val                       = sub_diff[aarf_pkg::DataW-1:0];
                            res.flags[aarf_pkg::FlagCarry] = sub_diff[aarf_pkg::DataW];
                        end
                        aarf_pkg::ALU_AND:
                        begin
                            zsp_val                       = acc & req.operand;
                            res.flags[aarf_pkg::FlagCarry] = 1'b0;
                        end
                        aarf_pkg::ALU_XOR:
                        begin
                            zsp_val                       = acc ^ req.operand;
                            res.flags[aarf_pkg::FlagCarry] = 1'b0;
                        end
                        aarf_pkg::ALU_OR:
                        begin
                            zsp_val                       = acc | req.operand;
                            res.flags[aarf_pkg::FlagCarry] = 1'b0;
                        end
                        aarf_pkg::ALU_CMP:
                        begin
                            // Compare sets all flags but leaves the accumulator alone.
                            zsp_val                       = sub_diff[aarf_pkg::DataW-1:0];
                            res.flags[aarf_pkg::FlagCarry] = sub_diff[aarf_pkg::DataW];
                            res.we                        = 1'b0;
                        end
                        default:
                        begin
                            zsp_val = '0;
                        end
                    endcase
                    res.value = zsp_val;
                    res.wdata = zsp_val;
                end
                aarf_pkg::REQ_ROTATE:
                begin
                    res.widx = aarf_pkg::IdxAcc;
                    res.we   = 1'b1;
                    unique case (aarf_pkg::rot_op_t'(req.op_sel[1:0]))
                        aarf_pkg::ROT_RLC:
                        begin
                            res.value                     = {acc[aarf_pkg::DataW-2:0], acc[aarf_pkg::DataW-1]};
                            res.flags[aarf_pkg::FlagCarry] = acc[aarf_pkg::DataW-1];
                        end
                        aarf_pkg::ROT_RRC:
                        begin
                            res.value                     = {acc[0], acc[aarf_pkg::DataW-1:1]};
                            res.flags[aarf_pkg::FlagCarry] = acc[0];
                        end
                        aarf_pkg::ROT_RAL:
                        begin
                            res.value                     = {acc[aarf_pkg::DataW-2:0], cin};
                            res.flags[aarf_pkg::FlagCarry] = acc[aarf_pkg::DataW-1];
                        end
                        aarf_pkg::ROT_RAR:
                        begin
                            res.value                     = {cin, acc[aarf_pkg::DataW-1:1]};
                            res.flags[aarf_pkg::FlagCarry] = acc[0];
                        end
                        default:
                        begin
                            res.value = acc;
                        end
                    endcase
                    res.wdata = res.value;
                end
                aarf_pkg::REQ_INC:
                begin
                    zsp_en    = 1'b1;
                    zsp_val   = sel_val + {{(aarf_pkg::DataW-1){1'b0}}, 1'b1};
                    res.value = zsp_val;
                    res.wdata = zsp_val;
                    res.we    = 1'b1;
                end
                aarf_pkg::REQ_DEC:
                begin
                    zsp_en    = 1'b1;
                    zsp_val   = sel_val - {{(aarf_pkg::DataW-1){1'b0}}, 1'b1};
                    res.value = zsp_val;
                    res.wdata = zsp_val;
                    res.we    = 1'b1;
                end
                aarf_pkg::REQ_WRITE:
                begin
                    res.value = req.operand;
                    res.wdata = req.operand;
                    res.we    = 1'b1;
                end
                aarf_pkg::REQ_READ:
                begin
                    res.value = sel_val;
                end
                default:
                begin
                    // Unused request kinds change nothing and return zero.
                    res.value = '0;
                end
            endcase
        end

        // Zero, sign and parity from the flag-setting value.
        if (zsp_en)
        begin
            res.flags[aarf_pkg::FlagZero]   = (zsp_val == '0);
            res.flags[aarf_pkg::FlagSign]   = zsp_val[aarf_pkg::DataW-1];
            res.flags[aarf_pkg::FlagParity] = ~^zsp_val;
        end
    end

endmodule

// ===== hw/rtl/accumulator_alu_register_file_unit.sv =====
// Top level of the execute unit: stream ports, register file, flags and result register.
//
// Execute unit of an 8-bit accumulator CPU with seven registers (register 0 is the
// accumulator) and carry, zero, sign and parity flags. Each request item on the slave
// stream yields exactly one result item on the master stream carrying the produced value
// and all four flags. The unit takes one item per cycle while m_tready is high: the
// register file and flags are updated at the accepting edge and the result lands in the
// output register at that same edge, so a result appears in the cycle after its request
// and the next request may follow immediately. The single output register is the only
// buffering; s_tready stays high while that register is empty or is being drained in the
// same cycle, so a stalled master side holds the input off after one result is waiting.
module accumulator_alu_register_file_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: req_type[2:0], op_sel[5:3], reg_index[8:6], operand[16:9], zero[23:17]
    input  logic [aarf_pkg::InDataW-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: value_out[7:0], carry_flag[8], zero_flag[9], sign_flag[10],
    // parity_flag[11], bad_index[12], zero[15:13]
    output logic [aarf_pkg::OutDataW-1:0] m_tdata
);

    logic [aarf_pkg::DataW-1:0]    reg_file_reg [aarf_pkg::NumRegs];
    logic [aarf_pkg::NumFlags-1:0] flag_reg;
    logic                          out_valid_reg;
    logic [aarf_pkg::DataW-1:0]    out_value_reg;
    logic [aarf_pkg::NumFlags-1:0] out_flags_reg;
    logic                          out_bad_reg;

    aarf_pkg::req_t                req;
    aarf_pkg::exec_t               res;
    logic [aarf_pkg::DataW-1:0]    sel_val;
    logic                          accept;

    // Handshake: accept whenever the result register is free or drains now.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Unpack the request item.
    assign req.req_type  = s_tdata[2:0];
    assign req.op_sel    = s_tdata[5:3];
    assign req.reg_index = s_tdata[8:6];
    assign req.operand   = s_tdata[16:9];

    // Selected register read; memory index reads as zero.
    assign sel_val = (req.reg_index != aarf_pkg::IdxMemory) ?
                     reg_file_reg[req.reg_index] : '0;

    aarf_exec u_exec (
        .req     (req),
        .acc     (reg_file_reg[0]),
        .sel_val (sel_val),
        .flags   (flag_reg),
        .res     (res)
    );

    // Architectural state update on each accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < aarf_pkg::NumRegs; i++)
            begin
                reg_file_reg[i] <= '0;
            end
            flag_reg <= '0;
        end
        else if (accept)
        begin
            flag_reg <= res.flags;
            if (res.we && (res.widx != aarf_pkg::IdxMemory))
            begin
                reg_file_reg[res.widx] <= res.wdata;
            end
        end
    end

    // Result register valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_value_reg <= res.value;
            out_flags_reg <= res.flags;
            out_bad_reg   <= res.bad;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_bad_reg, out_flags_reg, out_value_reg};

    // A rejected index leaves the flags as they were.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res.bad) |=> $stable(flag_reg))
        else $error("flags changed on a rejected register index");

    // Rotates touch only the carry flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.req_type == aarf_pkg::REQ_ROTATE)) |=>
        $stable(flag_reg[aarf_pkg::NumFlags-1:1]))
        else $error("rotate changed zero, sign or parity");

    // Compare leaves the accumulator unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.req_type == aarf_pkg::REQ_ALU) &&
         (req.op_sel == aarf_pkg::ALU_CMP)) |=> $stable(reg_file_reg[0]))
        else $error("compare wrote the accumulator");

    // The result item carries the flags that the state now holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (out_flags_reg == flag_reg))
        else $error("result flags differ from the flag register");

    // Input is held off only while a result waits on a stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (out_valid_reg && !m_tready))
        else $error("input stalled without a waiting result");

endmodule

// ===== sim/exec_unit_checker.sv =====
// Checker for the execute unit: shadow register file and flags, result prediction and comparison.
`timescale 1ns / 100ps

module exec_unit_checker
    import aarf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [InDataW-1:0]   s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [OutDataW-1:0]  m_tdata,
    output int                   fail_count,
    output int                   pending_count,
    output int                   checked_count
);

    // One result item as the unit reports it
    typedef struct packed {
        logic [DataW-1:0] value;
        logic             carry;
        logic             zero;
        logic             sign;
        logic             parity;
        logic             bad;
    } unit_result_t;

    logic [DataW-1:0]    shadow_regs [NumRegs];
    logic [NumFlags-1:0] shadow_flags;
    unit_result_t        predicted_results [$];
    unit_result_t        want;
    unit_result_t        fresh;

    // Zero, sign and parity always follow the 8-bit value that sets them.
    task automatic set_zsp(input logic [DataW-1:0] v);
        shadow_flags[FlagZero]   = (v == '0);
        shadow_flags[FlagSign]   = v[DataW-1];
        shadow_flags[FlagParity] = ~^v;
    endtask

    // Apply one request to the shadow state and work out the result item it causes.
    task automatic execute_request(input logic [InDataW-1:0] d, output unit_result_t r);
        logic [2:0]       kind;
        logic [2:0]       op;
        logic [IdxW-1:0]  idx;
        logic [DataW-1:0] b;
        logic [DataW-1:0] acc;
        logic [DataW:0]   wide;
        logic [DataW-1:0] v;
        logic             cin;
        logic             bad;
        kind = d[2:0];
        op   = d[5:3];
        idx  = d[8:6];
        b    = d[16:9];
        acc  = shadow_regs[IdxAcc];
        cin  = shadow_flags[FlagCarry];
        v    = '0;
        bad  = 1'b0;
        wide = '0;

        if ((kind == REQ_INC || kind == REQ_DEC || kind == REQ_WRITE || kind == REQ_READ)
            && idx == IdxMemory) begin
            // Memory index: nothing changes and the request is flagged.
            bad = 1'b1;
        end
        else begin
            case (kind)
                REQ_ALU:
                begin
                    case (op)
                        ALU_ADD: wide = {1'b0, acc} + {1'b0, b};
                        ALU_ADC: wide = {1'b0, acc} + {1'b0, b} + {{DataW{1'b0}}, cin};
                        ALU_SUB: wide = {1'b0, acc} - {1'b0, b};
                        ALU_SBB: wide = {1'b0, acc} - {1'b0, b} - {{DataW{1'b0}}, cin};
                        ALU_AND: wide = {1'b0, acc & b};
                        ALU_XOR: wide = {1'b0, acc ^ b};
                        ALU_OR:  wide = {1'b0, acc | b};
                        default: wide = {1'b0, acc} - {1'b0, b};
                    endcase
                    // Bit 8 of the 9-bit sum or difference is carry out or borrow.
                    v = wide[DataW-1:0];
                    shadow_flags[FlagCarry] = wide[DataW];
                    set_zsp(v);
                    if (op != ALU_CMP)
                        shadow_regs[IdxAcc] = v;
                end
                REQ_ROTATE:
                begin
                    case (op[1:0])
                        ROT_RLC:
                        begin
                            v = {acc[6:0], acc[7]};
                            shadow_flags[FlagCarry] = acc[7];
                        end
                        ROT_RRC:
                        begin
                            v = {acc[0], acc[7:1]};
                            shadow_flags[FlagCarry] = acc[0];
                        end
                        ROT_RAL:
                        begin
                            v = {acc[6:0], cin};
                            shadow_flags[FlagCarry] = acc[7];
                        end
                        default:
                        begin
                            v = {cin, acc[7:1]};
                            shadow_flags[FlagCarry] = acc[0];
                        end
                    endcase
                    shadow_regs[IdxAcc] = v;
                end
                REQ_INC:
                begin
                    shadow_regs[idx] = shadow_regs[idx] + DataW'(1);
                    v = shadow_regs[idx];
                    set_zsp(v);
                end
                REQ_DEC:
                begin
                    shadow_regs[idx] = shadow_regs[idx] - DataW'(1);
                    v = shadow_regs[idx];
                    set_zsp(v);
                end
                REQ_WRITE:
                begin
                    shadow_regs[idx] = b;
                    v = b;
                end
                REQ_READ:
                begin
                    v = shadow_regs[idx];
                end
                default:
                begin
                    // Unused request kinds leave everything alone.
                end
            endcase
        end

        r.value  = v;
        r.carry  = shadow_flags[FlagCarry];
        r.zero   = shadow_flags[FlagZero];
        r.sign   = shadow_flags[FlagSign];
        r.parity = shadow_flags[FlagParity];
        r.bad    = bad;
    endtask

    // Watch both streams: compare each accepted result, then predict each accepted request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < NumRegs; i++)
                shadow_regs[i] = '0;
            shadow_flags = '0;
            predicted_results.delete();
            fail_count    = 0;
            pending_count = 0;
            checked_count = 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (predicted_results.size() == 0) begin
                    $error("result item 0x%0h arrived with no request waiting", m_tdata);
                    fail_count++;
                end
                else begin
                    want = predicted_results.pop_front();
                    checked_count++;
                    if (m_tdata[7:0] != want.value) begin
                        $error("value_out: expected 0x%0h, got 0x%0h", want.value, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tdata[8] != want.carry) begin
                        $error("carry_flag: expected %0b, got %0b", want.carry, m_tdata[8]);
                        fail_count++;
                    end
                    if (m_tdata[9] != want.zero) begin
                        $error("zero_flag: expected %0b, got %0b", want.zero, m_tdata[9]);
                        fail_count++;
                    end
                    if (m_tdata[10] != want.sign) begin
                        $error("sign_flag: expected %0b, got %0b", want.sign, m_tdata[10]);
                        fail_count++;
                    end
                    if (m_tdata[11] != want.parity) begin
                        $error("parity_flag: expected %0b, got %0b", want.parity, m_tdata[11]);
                        fail_count++;
                    end
                    if (m_tdata[12] != want.bad) begin
                        $error("bad_index: expected %0b, got %0b", want.bad, m_tdata[12]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                execute_request(s_tdata, fresh);
                predicted_results.push_back(fresh);
            end
            pending_count = predicted_results.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the execute unit: clock, reset, request stimulus, result sink and verdict.
`timescale 1ns / 100ps

module tb;
    import aarf_pkg::*;

    localparam int  RandomItems  = 1700;
    localparam int  QuietTail    = 250;
    localparam int  HoldCycles   = 60;
    localparam int  CycleLimit   = 200000;
    localparam logic [2:0] ReqSpareLow  = 3'd6;
    localparam logic [2:0] ReqSpareHigh = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OutDataW-1:0] m_tdata;

    int fail_count;
    int pending_count;
    int checked_count;
    int cycle_count;
    int directed_sent;
    bit idle_on;

    accumulator_alu_register_file_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    exec_unit_checker result_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    // Free-running clock, 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit well above the slowest legal run.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_count);
            $display("FAIL accumulator_alu_register_file_unit");
            $finish;
        end
    end

    // Pack one request item into the slave tdata layout.
    function automatic logic [InDataW-1:0] pack_req(input logic [2:0] kind,
                                                     input logic [2:0] op,
                                                     input logic [IdxW-1:0] idx,
                                                     input logic [DataW-1:0] opnd);
        return {7'b0, opnd, idx, op, kind};
    endfunction

    // Draw a random request, weighted toward ALU work, with extreme operands now and then.
    function automatic logic [InDataW-1:0] random_request();
        int               pick;
        logic [2:0]       kind;
        logic [2:0]       op;
        logic [IdxW-1:0]  idx;
        logic [DataW-1:0] opnd;
        pick = $urandom_range(0, 99);
        op   = 3'($urandom_range(0, 7));
        idx  = ($urandom_range(0, 9) == 0) ? IdxMemory : IdxW'($urandom_range(0, NumRegs - 1));
        case ($urandom_range(0, 9))
            0:       opnd = 8'h00;
            1:       opnd = 8'hFF;
            2:       opnd = ($urandom_range(0, 1) == 0) ? 8'h80 : 8'h7F;
            default: opnd = DataW'($urandom_range(0, 255));
        endcase
        if (pick < 40)
            kind = REQ_ALU;
        else if (pick < 52)
            kind = REQ_ROTATE;
        else if (pick < 60)
            kind = REQ_INC;
        else if (pick < 68)
            kind = REQ_DEC;
        else if (pick < 82)
            kind = REQ_WRITE;
        else if (pick < 96)
            kind = REQ_READ;
        else
            kind = ($urandom_range(0, 1) == 0) ? ReqSpareLow : ReqSpareHigh;
        return pack_req(kind, op, idx, opnd);
    endfunction

    // Offer one item, with an optional idle burst first; returns at the accepting edge.
    task automatic send_item(input logic [InDataW-1:0] d);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Result sink: random stalls, two long hold-offs so the unit backs up, none at the end.
    initial
    begin
        int rx_cycles;
        int holds_done;
        int gap;
        rx_cycles  = 0;
        holds_done = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever begin
            if (holds_done < 2 && rx_cycles >= 600 + holds_done * 1800) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                rx_cycles += HoldCycles;
            end
            else if (idle_on && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 5);
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
                rx_cycles += gap;
            end
            else begin
                m_tready <= 1'b1;
                @(posedge clk);
                rx_cycles++;
            end
        end
    end

    // Reset, directed requests, random requests, drain and verdict.
    initial
    begin
        idle_on       = 1'b1;
        directed_sent = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Add and add with carry wrapping to zero.
        send_item(pack_req(REQ_WRITE, ALU_ADD, IdxAcc, 8'hFF));
        send_item(pack_req(REQ_ALU, ALU_ADD, 3'd5, 8'h01));
        send_item(pack_req(REQ_ALU, ALU_ADC, 3'd0, 8'hFF));
        // Subtract and subtract with borrow from zero, borrow set.
        send_item(pack_req(REQ_WRITE, ALU_ADD, IdxAcc, 8'h00));
        send_item(pack_req(REQ_ALU, ALU_SUB, 3'd0, 8'h01));
        send_item(pack_req(REQ_ALU, ALU_SBB, 3'd2, 8'hFF));
        // Logic ops clear carry; compare leaves the accumulator alone.
        send_item(pack_req(REQ_ALU, ALU_AND, 3'd0, 8'h0F));
        send_item(pack_req(REQ_ALU, ALU_XOR, 3'd7, 8'hFF));
        send_item(pack_req(REQ_ALU, ALU_OR, 3'd0, 8'h80));
        send_item(pack_req(REQ_ALU, ALU_CMP, 3'd0, 8'hFF));
        send_item(pack_req(REQ_READ, ALU_ADD, IdxAcc, 8'h00));
        // Every rotate, with the upper op_sel bit set on some of them.
        send_item(pack_req(REQ_WRITE, ALU_ADD, IdxAcc, 8'h81));
        send_item(pack_req(REQ_ROTATE, 3'd0, 3'd0, 8'h00));
        send_item(pack_req(REQ_ROTATE, 3'd5, 3'd7, 8'hFF));
        send_item(pack_req(REQ_ROTATE, 3'd2, 3'd0, 8'h00));
        send_item(pack_req(REQ_ROTATE, 3'd7, 3'd0, 8'h00));
        // Increment wrapping to zero and decrement wrapping to all ones.
        send_item(pack_req(REQ_WRITE, ALU_ADD, 3'd6, 8'hFF));
        send_item(pack_req(REQ_INC, ALU_ADD, 3'd6, 8'h00));
        send_item(pack_req(REQ_DEC, ALU_ADD, 3'd3, 8'h00));
        // The memory index is rejected by every register request.
        send_item(pack_req(REQ_INC, ALU_ADD, IdxMemory, 8'h00));
        send_item(pack_req(REQ_DEC, ALU_ADD, IdxMemory, 8'h00));
        send_item(pack_req(REQ_WRITE, ALU_ADD, IdxMemory, 8'hFF));
        send_item(pack_req(REQ_READ, ALU_ADD, IdxMemory, 8'h00));
        // Unused request kinds do nothing.
        send_item(pack_req(ReqSpareLow, 3'd7, 3'd7, 8'hFF));
        send_item(pack_req(ReqSpareHigh, 3'd0, 3'd0, 8'h00));
        directed_sent = 25;

        // Random traffic; the last stretch runs with no idling on either side.
        for (int n = 0; n < RandomItems; n++) begin
            if (n == RandomItems - QuietTail)
                idle_on = 1'b0;
            send_item(random_request());
        end
        s_tvalid <= 1'b0;

        // Drain: sample at the falling edge so the count is settled.
        do
            @(negedge clk);
        while (pending_count != 0);
        repeat (4) @(posedge clk);

        $display("Sent %0d directed and %0d random requests; %0d result items checked.",
                 directed_sent, RandomItems, checked_count);
        $display("Covered all ALU ops, rotates, wrapping inc/dec, register access, %s",
                 "memory index, unused kinds and stalls on both streams.");
        if (fail_count == 0 && pending_count == 0)
            $display("PASS accumulator_alu_register_file_unit");
        else
            $display("FAIL accumulator_alu_register_file_unit");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/aarf_pkg.sv
hw/rtl/aarf_exec.sv
hw/rtl/accumulator_alu_register_file_unit.sv
sim/exec_unit_checker.sv
sim/tb.sv
